[sv/sid_pkg.sv]
// Package for the 2D segment intersection block: widths, payload structs and
// pipeline stage types. No dependencies.
package sid_pkg;

  localparam int COORD_W  = 16;                 // coordinate width, signed Q11.4
  localparam int T_FRAC_W = 16;                 // fraction bits of t
  localparam int DIFF_W   = COORD_W + 1;        // coordinate difference
  localparam int PROD_W   = 2 * DIFF_W;         // product of two differences
  localparam int AREA_W   = PROD_W + 1;         // signed area
  localparam int DEN_W    = AREA_W + 1;         // a1 - a2
  localparam int WIDE_W   = AREA_W + 2;         // a3 + a2 - a1
  localparam int REM_W    = DEN_W + 1;          // divider partial remainder
  localparam int LERP_W   = T_FRAC_W + 1 + DIFF_W;
  localparam int PIPE_LAT = 5 + T_FRAC_W + 2;   // accept edge to result strobe

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [AREA_W-1:0]  area_t;
  typedef logic signed [DEN_W-1:0]   dsum_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [LERP_W-1:0]  lerp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] d_x;
    logic signed [COORD_W-1:0] d_y;
  } in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } out_t;

  // Start point of AB and its direction, carried down the pipeline.
  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    diff_t  dl_x;
    diff_t  dl_y;
    diff_t  dl_z;
  } seg_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic                 hit;
    logic [REM_W-1:0]     rem;
    logic [DEN_W-1:0]     den;
    logic [T_FRAC_W-1:0]  quo;
    seg_t                 seg;
  } div_t;

  function automatic diff_t sub_c(coord_t p, coord_t q);
    return diff_t'(p) - diff_t'(q);
  endfunction

  function automatic prod_t mul_d(diff_t p, diff_t q);
    return prod_t'(p) * prod_t'(q);
  endfunction

endpackage

[sv/segment_intersection_2d_top.sv]
// Each accepted beat strobes one result on out_valid after passing every stage;
// throughput is one beat per cycle through the 16-stage divider.
// busy stays low: the pipeline never stalls since the receiver takes every result.
// Reset (rst_n low, synchronous) clears all stage valid bits; in-flight beats drop.
// Depends on sid_pkg.
module segment_intersection_2d_top
  import sid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  // Stage 1: coordinate differences.
  logic  v1_r;
  diff_t adx_r, bdy_r, ady_r, bdx_r;
  diff_t acx_r, bcy_r, acy_r, bcx_r;
  diff_t cax_r, day_r, cay_r, dax_r;
  seg_t  seg1_r;

  // Stage 2: products.
  logic  v2_r;
  prod_t p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r;
  seg_t  seg2_r;

  // Stage 3: signed areas.
  logic  v3_r;
  area_t a1_r, a2_r, a3_r;
  seg_t  seg3_r;

  // Stage 4: a4 and the divisor before magnitude.
  logic  v4_r;
  logic  ok12_r;
  area_t a3b_r;
  wide_t a4_r;
  dsum_t dd_r;
  seg_t  seg4_r;

  // Divider stages; entry 0 is the stage 5 register.
  logic [T_FRAC_W:0] dv_r;
  div_t              div_r [T_FRAC_W+1];

  // Interpolation product stage.
  logic  v6_r;
  logic  hit6_r;
  lerp_t mx_r, my_r, mz_r;
  coord_t ax6_r, ay6_r, az6_r;

  // Output register.
  logic out_valid_r;
  out_t out_data_r;

  logic  hit5;
  logic  [REM_W-1:0] num5;
  logic  [DEN_W-1:0] den5;
  logic  [REM_W-1:0] a3_w;
  lerp_t t_s;

  // Shifted remainder and quotient bit of each divider stage.
  logic [REM_W-1:0]    shl_w [T_FRAC_W];
  logic [T_FRAC_W-1:0] ge_w;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      dv_r <= '0;
      v6_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r <= {dv_r[T_FRAC_W-1:0], v4_r};
      v6_r <= dv_r[T_FRAC_W];
      out_valid_r <= v6_r;
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    adx_r <= sub_c(in_data.a_x, in_data.d_x);
    bdy_r <= sub_c(in_data.b_y, in_data.d_y);
    ady_r <= sub_c(in_data.a_y, in_data.d_y);
    bdx_r <= sub_c(in_data.b_x, in_data.d_x);
    acx_r <= sub_c(in_data.a_x, in_data.c_x);
    bcy_r <= sub_c(in_data.b_y, in_data.c_y);
    acy_r <= sub_c(in_data.a_y, in_data.c_y);
    bcx_r <= sub_c(in_data.b_x, in_data.c_x);
    cax_r <= sub_c(in_data.c_x, in_data.a_x);
    day_r <= sub_c(in_data.d_y, in_data.a_y);
    cay_r <= sub_c(in_data.c_y, in_data.a_y);
    dax_r <= sub_c(in_data.d_x, in_data.a_x);
    seg1_r.a_x  <= in_data.a_x;
    seg1_r.a_y  <= in_data.a_y;
    seg1_r.a_z  <= in_data.a_z;
    seg1_r.dl_x <= sub_c(in_data.b_x, in_data.a_x);
    seg1_r.dl_y <= sub_c(in_data.b_y, in_data.a_y);
    seg1_r.dl_z <= sub_c(in_data.b_z, in_data.a_z);
  end

  // Stage 2
  always_ff @(posedge clk) begin
    p1a_r  <= mul_d(adx_r, bdy_r);
    p1b_r  <= mul_d(ady_r, bdx_r);
    p2a_r  <= mul_d(acx_r, bcy_r);
    p2b_r  <= mul_d(acy_r, bcx_r);
    p3a_r  <= mul_d(cax_r, day_r);
    p3b_r  <= mul_d(cay_r, dax_r);
    seg2_r <= seg1_r;
  end

  // Stage 3
  always_ff @(posedge clk) begin
    a1_r   <= area_t'(p1a_r) - area_t'(p1b_r);
    a2_r   <= area_t'(p2a_r) - area_t'(p2b_r);
    a3_r   <= area_t'(p3a_r) - area_t'(p3b_r);
    seg3_r <= seg2_r;
  end

  // Stage 4: a3 - a4 reduces to a1 - a2.
  always_ff @(posedge clk) begin
    ok12_r <= (a1_r != '0) && (a2_r != '0) && (a1_r[AREA_W-1] != a2_r[AREA_W-1]);
    a3b_r  <= a3_r;
    a4_r   <= wide_t'(a3_r) + wide_t'(a2_r) - wide_t'(a1_r);
    dd_r   <= dsum_t'(a1_r) - dsum_t'(a2_r);
    seg4_r <= seg3_r;
  end

  // Stage 5: hit decision and operand magnitudes. A miss feeds 0 / 1 so the
  // divider stays in range.
  always_comb begin
    hit5 = ok12_r && (a3b_r != '0) && (a4_r != '0) &&
           (a3b_r[AREA_W-1] != a4_r[WIDE_W-1]);
    a3_w = REM_W'(unsigned'(a3b_r[AREA_W-1] ? -wide_t'(a3b_r) : wide_t'(a3b_r)));
    num5 = hit5 ? a3_w : '0;
    den5 = hit5 ? (dd_r[DEN_W-1] ? DEN_W'(-dd_r) : DEN_W'(dd_r)) : DEN_W'(1);
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    for (int k = 0; k < T_FRAC_W; k++) begin
      shl_w[k] = {div_r[k].rem[REM_W-2:0], 1'b0};
      ge_w[k]  = shl_w[k] >= {1'b0, div_r[k].den};
    end
  end

  always_ff @(posedge clk) begin
    div_r[0].hit <= hit5;
    div_r[0].rem <= num5;
    div_r[0].den <= den5;
    div_r[0].quo <= '0;
    div_r[0].seg <= seg4_r;
    for (int k = 0; k < T_FRAC_W; k++) begin
      div_r[k+1].hit <= div_r[k].hit;
      div_r[k+1].rem <= ge_w[k] ? (shl_w[k] - {1'b0, div_r[k].den}) : shl_w[k];
      div_r[k+1].den <= div_r[k].den;
      div_r[k+1].quo <= {div_r[k].quo[T_FRAC_W-2:0], ge_w[k]};
      div_r[k+1].seg <= div_r[k].seg;
    end
  end

  // Interpolation: t * (B - A), t zero-extended to signed.
  assign t_s = lerp_t'($signed({1'b0, div_r[T_FRAC_W].quo}));

  always_ff @(posedge clk) begin
    hit6_r <= div_r[T_FRAC_W].hit;
    mx_r   <= t_s * lerp_t'(div_r[T_FRAC_W].seg.dl_x);
    my_r   <= t_s * lerp_t'(div_r[T_FRAC_W].seg.dl_y);
    mz_r   <= t_s * lerp_t'(div_r[T_FRAC_W].seg.dl_z);
    ax6_r  <= div_r[T_FRAC_W].seg.a_x;
    ay6_r  <= div_r[T_FRAC_W].seg.a_y;
    az6_r  <= div_r[T_FRAC_W].seg.a_z;
  end

  // Taking the upper bits is an arithmetic shift, which rounds toward minus
  // infinity; since t < 1 the sum fits the coordinate width.
  always_ff @(posedge clk) begin
    out_data_r.hit     <= hit6_r;
    out_data_r.point_x <= hit6_r ? ax6_r + coord_t'(mx_r[T_FRAC_W +: COORD_W]) : '0;
    out_data_r.point_y <= hit6_r ? ay6_r + coord_t'(my_r[T_FRAC_W +: COORD_W]) : '0;
    out_data_r.point_z <= hit6_r ? az6_r + coord_t'(mz_r[T_FRAC_W +: COORD_W]) : '0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/sid_checker.sv]
// Port-level checker for segment_intersection_2d_top, attached by bind.
// Depends on sid_pkg.
module sid_checker
  import sid_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  localparam int CNT_W = $clog2(PIPE_LAT + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             warm;

  // Counts cycles since reset so that history from before reset is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cnt_r != CNT_W'(PIPE_LAT)) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign warm = (cnt_r == CNT_W'(PIPE_LAT));

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised although the pipeline never stalls");

  a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(start && !busy, PIPE_LAT)))
    else $error("result strobe does not match an accepted beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |->
      (out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0))
    else $error("miss carries a nonzero point");

  a_hit_on_ab: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid && out_data.hit) |->
      ((out_data.point_x >= $past(in_data.a_x, PIPE_LAT) &&
        out_data.point_x <= $past(in_data.b_x, PIPE_LAT)) ||
       (out_data.point_x <= $past(in_data.a_x, PIPE_LAT) &&
        out_data.point_x >= $past(in_data.b_x, PIPE_LAT))))
    else $error("hit point x lies outside segment AB");

endmodule

bind segment_intersection_2d_top sid_checker u_sid_checker (.*);

[tb/segment_intersection_2d_top_test.sv]
// Testbench for segment_intersection_2d_top: drives segment pairs through the
// command port and checks every crossing result against an in-bench predictor.
// Depends on sid_pkg and segment_intersection_2d_top.
module segment_intersection_2d_top_test;
  import sid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1780;
  localparam int DRAIN_SLACK  = PIPE_LAT + 6;

  // Holds the predicted crossing of every accepted pair and checks results in order.
  class crossing_board;
    out_t expected_q[$];
    int   fails;
    int   hits;
    int   misses;
    int   pairs_in;

    function bit opposite(longint p, longint q);
      return (p > 0 && q < 0) || (p < 0 && q > 0);
    endfunction

    function out_t cross_point(in_t s);
      longint ax, ay, az, bx, by, bz, cx, cy, dx, dy;
      longint a1, a2, a3, a4, num, den, t;
      out_t   r;
      r  = '0;
      ax = s.a_x; ay = s.a_y; az = s.a_z;
      bx = s.b_x; by = s.b_y; bz = s.b_z;
      cx = s.c_x; cy = s.c_y; dx = s.d_x; dy = s.d_y;
      a1 = (ax - dx) * (by - dy) - (ay - dy) * (bx - dx);
      a2 = (ax - cx) * (by - cy) - (ay - cy) * (bx - cx);
      a3 = (cx - ax) * (dy - ay) - (cy - ay) * (dx - ax);
      a4 = a3 + a2 - a1;
      if (opposite(a1, a2) && opposite(a3, a4)) begin
        num = (a3 < 0) ? -a3 : a3;
        den = (a3 - a4 < 0) ? a4 - a3 : a3 - a4;
        t   = 0;
        // Restoring division gives the truncated fraction bit by bit.
        for (int i = 0; i < T_FRAC_W; i++) begin
          num = num << 1;
          t   = t << 1;
          if (num >= den) begin
            num = num - den;
            t   = t | 1;
          end
        end
        // An arithmetic shift of the signed product rounds toward minus infinity.
        r.hit     = 1'b1;
        r.point_x = coord_t'(ax + ((t * (bx - ax)) >>> T_FRAC_W));
        r.point_y = coord_t'(ay + ((t * (by - ay)) >>> T_FRAC_W));
        r.point_z = coord_t'(az + ((t * (bz - az)) >>> T_FRAC_W));
      end
      return r;
    endfunction

    function void note(in_t beat);
      expected_q.push_back(cross_point(beat));
      pairs_in++;
    endfunction

    function void check(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("Unexpected result with nothing pending: hit=%0b point=(%0d,%0d,%0d)",
                   got.hit, got.point_x, got.point_y, got.point_z);
        return;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit || got.point_x !== want.point_x ||
          got.point_y !== want.point_y || got.point_z !== want.point_z) begin
        fails++;
        if (fails <= 10)
          $display("Mismatch: expected hit=%0b point=(%0d,%0d,%0d), got hit=%0b point=(%0d,%0d,%0d)",
                   want.hit, want.point_x, want.point_y, want.point_z,
                   got.hit, got.point_x, got.point_y, got.point_z);
      end else if (want.hit) begin
        hits++;
      end else begin
        misses++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  crossing_board board = new;
  int            quiet_left;

  segment_intersection_2d_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && busy === 1'b0) board.note(in_data);
      if (out_valid === 1'b1) board.check(out_data);
    end
  end

  function automatic coord_t fit(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic in_t make_pair(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int dx, int dy);
    in_t s;
    s.a_x = fit(ax); s.a_y = fit(ay); s.a_z = fit(az);
    s.b_x = fit(bx); s.b_y = fit(by); s.b_z = fit(bz);
    s.c_x = fit(cx); s.c_y = fit(cy); s.d_x = fit(dx); s.d_y = fit(dy);
    return s;
  endfunction

  // Magnitude drawn from a random power of two so that short and long segments both occur.
  function automatic int scaled_coord();
    int mag;
    mag = 1 << $urandom_range(15, 2);
    return int'($urandom_range(2 * mag, 0)) - mag;
  endfunction

  function automatic int corner_coord();
    int pick;
    pick = $urandom_range(6, 0);
    case (pick)
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic in_t random_pair();
    int   kind, k, r;
    int   ax, ay, az, bx, by, bz, px, py, ux, uy, wx, wy;
    in_t  s;
    kind = $urandom_range(99, 0);
    ax = scaled_coord(); ay = scaled_coord(); az = int'(coord_t'($urandom()));
    bx = scaled_coord(); by = scaled_coord(); bz = int'(coord_t'($urandom()));
    ux = scaled_coord(); uy = scaled_coord();
    if (kind < 30) begin
      s = in_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    end else if (kind < 68) begin
      // Pick a point on AB and run CD through it in a random direction.
      r  = $urandom_range(255, 1);
      px = ax + ((bx - ax) * r) / 256;
      py = ay + ((by - ay) * r) / 256;
      k  = $urandom_range(16, 1);
      s  = make_pair(ax, ay, az, bx, by, bz, px + ux, py + uy,
                     px - (ux * k) / 4, py - (uy * k) / 4);
    end else if (kind < 80) begin
      s = make_pair($urandom_range(12, 0) - 6, $urandom_range(12, 0) - 6, az,
                    $urandom_range(12, 0) - 6, $urandom_range(12, 0) - 6, bz,
                    $urandom_range(12, 0) - 6, $urandom_range(12, 0) - 6,
                    $urandom_range(12, 0) - 6, $urandom_range(12, 0) - 6);
    end else if (kind < 92) begin
      // Touching, collinear and parallel arrangements built from a short step u.
      ux = $urandom_range(400, 0) - 200;
      uy = $urandom_range(400, 0) - 200;
      ax = ax / 4; ay = ay / 4;
      wx = $urandom_range(400, 0) - 200;
      wy = $urandom_range(400, 0) - 200;
      case ($urandom_range(4, 0))
        0: s = make_pair(ax, ay, az, ax + 2 * ux, ay + 2 * uy, bz, ax, ay, ax + wx, ay + wy);
        1: s = make_pair(ax, ay, az, ax + 2 * ux, ay + 2 * uy, bz, ax + wx, ay + wy,
                         ax + ux, ay + uy);
        2: s = make_pair(ax, ay, az, ax + 2 * ux, ay + 2 * uy, bz, ax + 3 * ux, ay + 3 * uy,
                         ax - ux, ay - uy);
        3: s = make_pair(ax, ay, az, ax + 2 * ux, ay + 2 * uy, bz, ax + wx, ay + wy,
                         ax + 2 * ux + wx, ay + 2 * uy + wy);
        default: s = make_pair(ax, ay, az, ax + 2 * ux, ay + 2 * uy, bz,
                               ax + 2 * ux - wx, ay + 2 * uy - wy,
                               ax + 2 * ux + wx, ay + 2 * uy + wy);
      endcase
    end else begin
      s = make_pair(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                    corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                    corner_coord(), corner_coord());
    end
    return s;
  endfunction

  // Returns at the edge that accepts the beat, with nothing scheduled yet for that edge.
  task automatic drive_beat(in_t beat);
    start   <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause_sender();
    int r, n;
    r = $urandom_range(99, 0);
    n = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else if (r < 3) begin
      quiet_left = $urandom_range(120, 30);
    end else if (r < 55) begin
      n = 0;
    end else if (r < 88) begin
      n = $urandom_range(3, 1);
    end else if (r < 97) begin
      n = $urandom_range(25, 4);
    end else begin
      n = $urandom_range(60, 26);
    end
    if (n > 0) begin
      start   <= 1'b0;
      in_data <= random_pair();
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds the sender off until every predicted crossing has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    @(posedge clk);
  endtask

  initial begin
    in_t directed_q[$];
    start      = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    quiet_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    directed_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_pair(-160, 0, 0, 160, 0, 320, 0, -160, 0, 160));
    directed_q.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, 32767,
                                   -32768, 32767, 32767, -32768));
    directed_q.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768,
                                   32767, -32768, -32768, 32767));
    directed_q.push_back(make_pair(-32768, 0, 32767, 32767, 0, -32768, 0, -32768, 0, 32767));
    directed_q.push_back(make_pair(0, -32768, -32768, 0, 32767, 32767, 32767, 1, -32768, -1));
    // Endpoint of one segment lying on the other, each of the four ways.
    directed_q.push_back(make_pair(0, 0, 0, 100, 0, 0, 50, 0, 50, 50));
    directed_q.push_back(make_pair(0, 0, 0, 100, 0, 0, 50, -50, 50, 0));
    directed_q.push_back(make_pair(0, 0, 5, 100, 0, 5, 0, -50, 0, 50));
    directed_q.push_back(make_pair(0, 0, 5, 100, 0, 5, 100, -50, 100, 50));
    directed_q.push_back(make_pair(0, 0, 0, 100, 100, 0, 50, 50, 150, 150));
    directed_q.push_back(make_pair(0, 0, 0, 100, 0, 0, 0, 10, 100, 10));
    directed_q.push_back(make_pair(10, 10, 7, 10, 10, 7, 0, 0, 20, 20));
    directed_q.push_back(make_pair(0, 0, 0, 100, 0, 0, 50, 10, 50, 10));
    directed_q.push_back(make_pair(0, 0, 0, 100, 0, 0, 200, -50, 200, 50));
    directed_q.push_back(make_pair(0, 0, 0, 100, 0, 0, 10, 10, 90, 30));
    directed_q.push_back(make_pair(100, 100, -100, -100, -100, 100, 99, -200, 99, 300));
    directed_q.push_back(make_pair(-1000, 3, 0, 1000, -7, -32768, 999, -500, 999, 500));
    directed_q.push_back(make_pair(0, 0, 0, 1, 1, 1, 0, 1, 1, 0));
    directed_q.push_back(make_pair(1, 1, -1, 0, 0, 0, 1, 0, 0, 1));
    directed_q.push_back(make_pair(-16, 0, -32768, 16, 0, 32767, 0, -16, 0, 16));
    directed_q.push_back(make_pair(-32768, -32768, 0, 32767, 32767, 0, -32768, -32768, 0, 32767));

    foreach (directed_q[i]) begin
      drive_beat(directed_q[i]);
      pause_sender();
    end
    drain_results();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 600 || n == 1200) drain_results();
      drive_beat(random_pair());
      pause_sender();
    end

    drain_results();
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("Ran %0d segment pairs: %0d crossings and %0d misses matched, %0d errors.",
             board.pairs_in, board.hits, board.misses, board.fails);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results still pending.", board.pending());
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
sv/sid_pkg.sv
sv/segment_intersection_2d_top.sv
sv/sid_checker.sv
tb/segment_intersection_2d_top_test.sv
